[rtl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, off while reset is asserted
`define ASSERT_NXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

// next-cycle implication that is checked during reset too
`define ASSERT_NXT_ALWAYS(label, clk, pre, post, msg) \
    label: assert property (@(posedge clk) (pre) |=> (post)) else $error(msg);

`endif

[rtl/slt_pkg.sv]
`default_nettype none
package slt_pkg;

    // default sizes
    localparam int DEFAULT_DEPTH      = 16;
    localparam int DEFAULT_DATA_WIDTH = 32;

    // port widths
    localparam int OPCODE_W = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // opcodes
    localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_SEARCH = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_DELETE = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_POP    = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_DUMP   = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // command handed from the front queue to the cell row
    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [VALUE_W-1:0]  value;
    } t_cmd;

endpackage
`default_nettype wire

[rtl/slt_front.sv]
`default_nettype none
module slt_front import slt_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [OPCODE_W-1:0] i_opcode,
    input  wire logic [VALUE_W-1:0]  i_value,
    output logic                     o_q_valid,
    output t_cmd                     o_q_cmd,
    input  wire logic                i_q_pop
);

    t_cmd       r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;
    logic       w_op_known;
    logic       w_push;

    // drop unknown opcodes at the door, they produce no result
    always_comb begin
        unique case (i_opcode) inside
            OP_INSERT, OP_SEARCH, OP_DELETE, OP_POP, OP_DUMP: w_op_known = 1'b1;
            default: w_op_known = 1'b0;
        endcase
    end

    assign busy      = (r_fill == 2'd2);
    assign w_push    = start && !busy && w_op_known;
    assign o_q_valid = (r_fill != 2'd0);
    assign o_q_cmd   = r_q[r_rd_ptr];

    // two-entry queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= '{opcode: i_opcode, value: i_value};
        end
    end

    // queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_q_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (w_push && !i_q_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (!w_push && i_q_pop) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

[rtl/slt_back.sv]
`default_nettype none
module slt_back import slt_pkg::*; #(
    parameter int DEPTH      = DEFAULT_DEPTH,
    parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_q_valid,
    input  t_cmd                      i_q_cmd,
    output logic                      o_q_pop,
    output logic                      o_valid,
    output logic [STATUS_W-1:0]       o_status,
    output logic signed [VALUE_W-1:0] o_result_value,
    output logic [COUNT_W-1:0]        o_entry_count,
    output logic                      o_last
);

    localparam int CW = $clog2(DEPTH + 1);

    // cell row, no reset: only cells below the count are ever looked at
    logic [DATA_WIDTH-1:0] r_cells [DEPTH];
    logic [DATA_WIDTH-1:0] n_cells [DEPTH];
    logic [DATA_WIDTH-1:0] w_up    [DEPTH];
    logic [DATA_WIDTH-1:0] w_dn    [DEPTH];

    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_left, n_left;
    logic                  r_dumping, n_dumping;
    logic                  r_valid, n_valid;
    logic [STATUS_W-1:0]   r_status, n_status;
    logic [DATA_WIDTH-1:0] r_result, n_result;
    logic                  r_last, n_last;

    logic [DATA_WIDTH-1:0] w_val;
    logic [DATA_WIDTH-1:0] w_key;
    logic [DEPTH-1:0]      w_lt;
    logic [DEPTH-1:0]      w_eq;
    logic                  w_found;
    logic                  w_take;
    logic                  do_ins, do_del, do_pop, do_rot;

    // flipping the sign bit turns signed order into unsigned order
    function automatic logic [DATA_WIDTH-1:0] order_key(input logic [DATA_WIDTH-1:0] v);
        order_key = {~v[DATA_WIDTH-1], v[DATA_WIDTH-2:0]};
    endfunction

    assign w_val   = DATA_WIDTH'(i_q_cmd.value);
    assign w_key   = order_key(w_val);
    assign w_take  = i_q_valid && !r_dumping;
    assign o_q_pop = w_take;
    assign w_found = |w_eq;

    // per-cell compares and the update of each cell
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        assign w_lt[i] = (CW'(i) < r_count) && (order_key(r_cells[i]) < w_key);
        assign w_eq[i] = (CW'(i) < r_count) && (r_cells[i] == w_val);

        if (i == DEPTH - 1) begin : g_top
            assign w_up[i] = r_cells[i];
        end else begin : g_mid
            assign w_up[i] = r_cells[i + 1];
        end

        if (i == 0) begin : g_bottom
            assign w_dn[i] = w_val;
        end else begin : g_above
            assign w_dn[i] = w_lt[i - 1] ? w_val : r_cells[i - 1];
        end

        always_comb begin
            n_cells[i] = r_cells[i];
            if (do_ins && !w_lt[i]) begin
                n_cells[i] = w_dn[i];
            end else if (do_del && !w_lt[i]) begin
                n_cells[i] = w_up[i];
            end else if (do_pop) begin
                n_cells[i] = w_up[i];
            end else if (do_rot) begin
                if (CW'(i + 1) == r_count) begin
                    n_cells[i] = r_cells[0];
                end else if (CW'(i + 1) < r_count) begin
                    n_cells[i] = w_up[i];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_cells[i] <= n_cells[i];
        end
    end

    // command execution and dump sequencing
    always_comb begin
        n_count   = r_count;
        n_left    = r_left;
        n_dumping = r_dumping;
        n_valid   = 1'b0;
        n_status  = ST_OK;
        n_result  = w_val;
        n_last    = 1'b1;
        do_ins    = 1'b0;
        do_del    = 1'b0;
        do_pop    = 1'b0;
        do_rot    = 1'b0;
        if (r_dumping) begin
            n_valid  = 1'b1;
            n_result = r_cells[0];
            do_rot   = 1'b1;
            n_last   = (r_left == CW'(1));
            n_left   = r_left - CW'(1);
            if (r_left == CW'(1)) begin
                n_dumping = 1'b0;
            end
        end else if (i_q_valid) begin
            n_valid = 1'b1;
            unique case (i_q_cmd.opcode)
                OP_INSERT: begin
                    if (r_count == CW'(DEPTH)) begin
                        n_status = ST_FULL;
                    end else begin
                        do_ins  = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                end
                OP_SEARCH: begin
                    n_status = w_found ? ST_OK : ST_NOT_FOUND;
                end
                OP_DELETE: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else if (w_found) begin
                        do_del  = 1'b1;
                        n_count = r_count - CW'(1);
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end
                OP_POP: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        do_pop   = 1'b1;
                        n_result = r_cells[0];
                        n_count  = r_count - CW'(1);
                    end
                end
                OP_DUMP: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        // first entry goes out now, the rest one per cycle
                        n_result = r_cells[0];
                        do_rot   = 1'b1;
                        n_last   = (r_count == CW'(1));
                        n_left   = r_count - CW'(1);
                        n_dumping = (r_count != CW'(1));
                    end
                end
                default: begin
                    n_valid = 1'b0;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_left    <= '0;
            r_dumping <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_left    <= n_left;
            r_dumping <= n_dumping;
            r_valid   <= n_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_result <= n_result;
        r_last   <= n_last;
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_result_value = VALUE_W'($signed(r_result));
    assign o_entry_count  = COUNT_W'(r_count);
    assign o_last         = r_last;

endmodule
`default_nettype wire

[rtl/sorted_list_table.sv]
// Sorted list table: keeps up to DEPTH signed values in ascending order and runs insert,
// search, delete, pop and dump commands. A command is taken when start is high and busy is
// low; it enters a two-entry queue, and the cell row behind it carries out insert, search,
// delete and pop with every cell comparing against the request value at once, so these
// sustain one item per cycle while no dump holds the cell row; each command is registered
// in the queue and its result in the result register that drives o_valid. Dump
// sends out one entry per cycle and holds the cell row until its last entry is out; busy
// rises when the queue fills behind it. Each result is shown for exactly one cycle with
// o_valid high and cannot be stalled, so the receiver must take it then; o_last marks the
// final result of an item. Opcodes 5 to 7 are taken and dropped without any result.
`default_nettype none
module sorted_list_table import slt_pkg::*; #(
    parameter int DEPTH      = DEFAULT_DEPTH,
    parameter int DATA_WIDTH = DEFAULT_DATA_WIDTH
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [OPCODE_W-1:0]         i_opcode,
    input  wire logic signed [VALUE_W-1:0]   i_value,
    output logic                             o_valid,
    output logic [STATUS_W-1:0]              o_status,
    output logic signed [VALUE_W-1:0]        o_result_value,
    output logic [COUNT_W-1:0]               o_entry_count,
    output logic                             o_last
);

    logic w_q_valid;
    t_cmd w_q_cmd;
    logic w_q_pop;

    // command intake and queue
    slt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_opcode  (i_opcode),
        .i_value   (i_value),
        .o_q_valid (w_q_valid),
        .o_q_cmd   (w_q_cmd),
        .i_q_pop   (w_q_pop)
    );

    // cell row and result register
    slt_back #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (w_q_valid),
        .i_q_cmd        (w_q_cmd),
        .o_q_pop        (w_q_pop),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_result_value (o_result_value),
        .o_entry_count  (o_entry_count),
        .o_last         (o_last)
    );

endmodule
`default_nettype wire

[rtl/slt_checker.sv]
`default_nettype none
`include "assert_macros.svh"
module slt_checker import slt_pkg::*; #(
    parameter int DEPTH = DEFAULT_DEPTH
) (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                busy,
    input wire logic                o_valid,
    input wire logic [STATUS_W-1:0] o_status,
    input wire logic [COUNT_W-1:0]  o_entry_count,
    input wire logic                o_last
);

    // queue comes out of reset empty
    `ASSERT_NXT_ALWAYS(a_reset_not_busy, i_clk, !i_rst_n, !busy, "busy after reset")

    // a refused insert only happens on a full list
    `ASSERT_IMP(a_full_count, i_clk, i_rst_n, o_valid && (o_status == ST_FULL),
        o_entry_count == COUNT_W'(DEPTH), "full status with list not full")

    // an empty report is a single final result on an empty list
    `ASSERT_IMP(a_empty_count, i_clk, i_rst_n, o_valid && (o_status == ST_EMPTY),
        (o_entry_count == '0) && o_last, "empty status with entries held")

    // a dump streams without gaps until its last entry
    `ASSERT_NXT(a_dump_stream, i_clk, i_rst_n, o_valid && !o_last,
        o_valid && (o_status == ST_OK), "gap inside a dump")

    // the count never exceeds the depth
    `ASSERT_IMP(a_count_range, i_clk, i_rst_n, o_valid,
        (DEPTH > 31) || (o_entry_count <= COUNT_W'(DEPTH)), "count above depth")

endmodule

bind sorted_list_table slt_checker #(.DEPTH(DEPTH)) u_slt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_status      (o_status),
    .o_entry_count (o_entry_count),
    .o_last        (o_last)
);
`default_nettype wire

[verif/slt_checker.sv]
`timescale 1ns / 1ps
module tb_slt_checker import slt_pkg::*; #(
    parameter int DEPTH = DEFAULT_DEPTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_busy,
    input  logic [OPCODE_W-1:0]       i_opcode,
    input  logic signed [VALUE_W-1:0] i_value,
    input  logic                      i_res_valid,
    input  logic [STATUS_W-1:0]       i_res_status,
    input  logic signed [VALUE_W-1:0] i_res_value,
    input  logic [COUNT_W-1:0]        i_res_count,
    input  logic                      i_res_last,
    output int                        o_fail_count,
    output int                        o_pending,
    output int                        o_items,
    output int                        o_results,
    output int                        o_full_refusals,
    output int                        o_peak_len
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] value;
        logic [COUNT_W-1:0]        count;
        logic                      last;
    } t_list_result;

    // shadow copy of the sorted list
    logic signed [VALUE_W-1:0] list_mem [DEPTH];
    int                        list_len;

    // results still owed by the block, oldest first
    t_list_result result_q[$];

    function automatic void push_result(input logic [STATUS_W-1:0] st,
                                        input logic signed [VALUE_W-1:0] v,
                                        input logic fin);
        t_list_result r;
        r.status = st;
        r.value  = v;
        r.count  = COUNT_W'(list_len);
        r.last   = fin;
        result_q.push_back(r);
    endfunction

    function automatic void remove_entry(input int pos);
        int i;
        for (i = pos; i < list_len - 1; i++)
            list_mem[i] = list_mem[i + 1];
        list_len--;
    endfunction

    // apply one item to the shadow list and queue the results it causes
    function automatic void predict_list_op(input logic [OPCODE_W-1:0] op,
                                            input logic signed [VALUE_W-1:0] v);
        int i;
        int pos;
        int hit;
        logic signed [VALUE_W-1:0] head;
        hit = -1;
        for (i = 0; i < list_len; i++)
            if (hit < 0 && list_mem[i] == v)
                hit = i;
        case (op)
            OP_INSERT: begin
                if (list_len >= DEPTH) begin
                    o_full_refusals++;
                    push_result(ST_FULL, v, 1'b1);
                end else begin
                    pos = 0;
                    while (pos < list_len && list_mem[pos] < v)
                        pos++;
                    for (i = list_len; i > pos; i--)
                        list_mem[i] = list_mem[i - 1];
                    list_mem[pos] = v;
                    list_len++;
                    push_result(ST_OK, v, 1'b1);
                end
            end
            OP_SEARCH: begin
                push_result((hit >= 0) ? ST_OK : ST_NOT_FOUND, v, 1'b1);
            end
            OP_DELETE: begin
                if (list_len == 0) begin
                    push_result(ST_EMPTY, v, 1'b1);
                end else if (hit >= 0) begin
                    remove_entry(hit);
                    push_result(ST_OK, v, 1'b1);
                end else begin
                    push_result(ST_NOT_FOUND, v, 1'b1);
                end
            end
            OP_POP: begin
                if (list_len == 0) begin
                    push_result(ST_EMPTY, v, 1'b1);
                end else begin
                    head = list_mem[0];
                    remove_entry(0);
                    push_result(ST_OK, head, 1'b1);
                end
            end
            OP_DUMP: begin
                if (list_len == 0) begin
                    push_result(ST_EMPTY, v, 1'b1);
                end else begin
                    for (i = 0; i < list_len; i++)
                        push_result(ST_OK, list_mem[i], i == list_len - 1);
                end
            end
            default: begin
                // unused opcodes are dropped without a result
            end
        endcase
        if (list_len > o_peak_len)
            o_peak_len = list_len;
    endfunction

    function automatic void note_failure(input string what, input t_list_result want,
                                         input t_list_result seen);
        o_fail_count++;
        if (o_fail_count <= MAX_REPORTS)
            $display({"%0t: %s: expected status %0d value %0d count %0d last %0d, ",
                      "got %0d %0d %0d %0d"},
                     $realtime, what, want.status, want.value, want.count, want.last,
                     seen.status, seen.value, seen.count, seen.last);
    endfunction

    // sample mid-cycle so the view does not depend on edge ordering
    always @(negedge i_clk) begin
        t_list_result seen;
        t_list_result want;
        if (!i_rst_n) begin
            list_len        = 0;
            result_q.delete();
            o_fail_count    = 0;
            o_pending       = 0;
            o_items         = 0;
            o_results       = 0;
            o_full_refusals = 0;
            o_peak_len      = 0;
        end else begin
            // compare each result with the oldest prediction
            if (i_res_valid) begin
                o_results++;
                seen.status = i_res_status;
                seen.value  = i_res_value;
                seen.count  = i_res_count;
                seen.last   = i_res_last;
                if (result_q.size() == 0) begin
                    note_failure("result with nothing outstanding", '0, seen);
                end else begin
                    want = result_q.pop_front();
                    if (seen.status !== want.status || seen.value !== want.value ||
                        seen.count !== want.count || seen.last !== want.last)
                        note_failure("result mismatch", want, seen);
                end
            end
            // predict each accepted item
            if (i_start && !i_busy) begin
                o_items++;
                predict_list_op(i_opcode, i_value);
            end
            o_pending = result_q.size();
        end
    end

endmodule

[verif/tb_sorted_list_table.sv]
`timescale 1ns / 1ps
module tb_sorted_list_table;
    import slt_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 11;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int BURSTS       = 6;
    localparam int BURST_ITEMS  = 17;

    // opcodes the block takes and drops
    localparam logic [OPCODE_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [OPCODE_W-1:0] OP_UNUSED_HI = 3'd7;

    localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

    logic                      i_clk;
    logic                      i_rst_n  = 1'b0;
    logic                      start    = 1'b0;
    logic                      busy;
    logic [OPCODE_W-1:0]       i_opcode = OP_INSERT;
    logic signed [VALUE_W-1:0] i_value  = '0;
    logic                      o_valid;
    logic [STATUS_W-1:0]       o_status;
    logic signed [VALUE_W-1:0] o_result_value;
    logic [COUNT_W-1:0]        o_entry_count;
    logic                      o_last;

    int fail_cnt;
    int pending_cnt;
    int item_cnt;
    int result_cnt;
    int full_cnt;
    int peak_len;

    int idle_pct;
    int stall_cycles = 0;

    // insert share and sender idling per random burst
    int burst_ins[BURSTS]  = '{85, 25, 90, 45, 10, 60};
    int burst_idle[BURSTS] = '{0, 50, 12, 0, 50, 12};

    sorted_list_table u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_result_value (o_result_value),
        .o_entry_count  (o_entry_count),
        .o_last         (o_last)
    );

    tb_slt_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_opcode        (i_opcode),
        .i_value         (i_value),
        .i_res_valid     (o_valid),
        .i_res_status    (o_status),
        .i_res_value     (o_result_value),
        .i_res_count     (o_entry_count),
        .i_res_last      (o_last),
        .o_fail_count    (fail_cnt),
        .o_pending       (pending_cnt),
        .o_items         (item_cnt),
        .o_results       (result_cnt),
        .o_full_refusals (full_cnt),
        .o_peak_len      (peak_len)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // present one item, holding it until the block takes it
    task automatic issue_cmd(input logic [OPCODE_W-1:0] op,
                             input logic signed [VALUE_W-1:0] v);
        logic took;
        while (int'($urandom_range(99)) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start    <= 1'b1;
        i_opcode <= op;
        i_value  <= v;
        do begin
            @(negedge i_clk);
            took = !busy;
            @(posedge i_clk);
        end while (!took);
    endtask

    // small values collide often so search and delete hit
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int k;
        k = $urandom_range(8);
        case ($urandom_range(9))
            0, 1, 2, 3: return k - 4;
            4:          return $urandom_range(1) ? VAL_MAX : VAL_MIN;
            default:    return $urandom();
        endcase
    endfunction

    function automatic logic [OPCODE_W-1:0] pick_op(input int ins_pct);
        if (int'($urandom_range(99)) < ins_pct)
            return OP_INSERT;
        case ($urandom_range(9))
            0, 1, 2: return OP_SEARCH;
            3, 4, 5: return OP_DELETE;
            6, 7:    return OP_POP;
            8:       return OP_DUMP;
            default: return OPCODE_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
        endcase
    endfunction

    // watchdog on cycles with no item and no result
    always @(negedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        idle_pct = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty list cases and dropped opcodes
        issue_cmd(OP_DUMP, 32'sd7);
        issue_cmd(OP_POP, -32'sd9);
        issue_cmd(OP_DELETE, 32'sd1);
        issue_cmd(OP_SEARCH, 32'sd0);
        issue_cmd(OP_UNUSED_LO, 32'sd5);
        issue_cmd(OP_UNUSED_HI, -32'sd5);

        // value extremes and a duplicate
        issue_cmd(OP_INSERT, VAL_MAX);
        issue_cmd(OP_INSERT, VAL_MIN);
        issue_cmd(OP_INSERT, 32'sd0);
        issue_cmd(OP_INSERT, -32'sd1);
        issue_cmd(OP_INSERT, 32'sd0);
        issue_cmd(OP_SEARCH, 32'sd0);
        issue_cmd(OP_SEARCH, 32'sd5);
        issue_cmd(OP_DUMP, 32'sd0);
        issue_cmd(OP_DELETE, -32'sd1);
        issue_cmd(OP_DELETE, 32'sd123);
        issue_cmd(OP_POP, 32'sd0);
        issue_cmd(OP_DUMP, 32'sd0);

        // random bursts whose insert share grows or shrinks the list
        for (int b = 0; b < BURSTS; b++) begin
            idle_pct = burst_idle[b];
            for (int n = 0; n < BURST_ITEMS; n++)
                issue_cmd(pick_op(burst_ins[b]), pick_value());
        end
        start <= 1'b0;

        // drain outstanding results, then watch for strays
        repeat (2) @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d items and %0d results, list peak %0d entries",
                 item_cnt, result_cnt, peak_len);
        $display("%0d inserts refused on a full list, %0d failures", full_cnt, fail_cnt);
        if (fail_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
